// ===== rtl/pccr_pkg.sv =====
// Package for the pairwise circle collision resolver.
// Holds widths, position limits, sequencer state type and a saturation helper; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pccr_pkg;
	localparam int MaxBalls = 64;
	localparam int IdxW = 6;
	localparam int CntW = 7;
	localparam int PosW = 20;
	localparam int RadW = 14;
	localparam int Guard = 8;
	localparam int DifW = 21;
	localparam int D2W = 43;
	localparam int SqW = D2W + 2 * Guard + 1;
	localparam int RootW = 30;
	localparam int NumW = 53;
	localparam logic signed [PosW-1:0] PosMax = 20'sh7FFFF;
	localparam logic signed [PosW-1:0] PosMin = -20'sh80000;

	typedef enum logic [4:0] {
		ST_LOAD, ST_PI, ST_PJ, ST_RDI, ST_RDJ, ST_D2A, ST_D2B, ST_TEST,
		ST_SQRT, ST_EX, ST_DVX, ST_EY, ST_DVY, ST_WRI, ST_WRJ, ST_NEXT,
		ST_ORD, ST_OUT
	} state_t;

	function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW+1:0] v);
		if (v > 22'(PosMax)) return PosMax;
		if (v < 22'(PosMin)) return PosMin;
		return v[PosW-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/pccr_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both axes.
// Depends on pccr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pccr_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [pccr_pkg::NumW-1:0] num,
	input  wire logic [pccr_pkg::RootW:0] den,
	output logic done,
	output logic [pccr_pkg::NumW-1:0] quo
);
	import pccr_pkg::*;
	logic [RootW+1:0] rem_q;
	logic [NumW-1:0] q_q;
	logic [RootW:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [RootW+2:0] trial;

	assign trial = {rem_q, q_q[NumW-1]} - {2'b0, den_q};
	assign quo = q_q;

	// Shift one numerator bit in, subtract when it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[RootW+2]) begin
				rem_q <= trial[RootW+1:0];
				q_q <= {q_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[RootW:0], q_q[NumW-1]};
				q_q <= {q_q[NumW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/pairwise_circle_collision_resolve.sv =====
// Top level of the pairwise circle collision resolver.
// Depends on pccr_pkg and pccr_div.
//
// Circles load at one beat per cycle into a 64-entry store. The beat marked
// last starts one pass over all pairs i<j, then every stored position is
// emitted in load order, one beat per cycle while out_stall is low. During
// the pass and the emission the input is stalled. An overlapping pair adds
// a square root (one result bit per cycle) and two divisions on the shared
// divider.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_circle_collision_resolve (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [pccr_pkg::PosW-1:0] pos_x,
	input  wire logic signed [pccr_pkg::PosW-1:0] pos_y,
	input  wire logic [pccr_pkg::RadW-1:0] circle_radius,
	input  wire logic is_link,
	input  wire logic last_ball,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [pccr_pkg::IdxW-1:0] ball_index,
	output logic signed [pccr_pkg::PosW-1:0] new_x,
	output logic signed [pccr_pkg::PosW-1:0] new_y,
	output logic last_result
);
	import pccr_pkg::*;

	logic signed [PosW-1:0] xm [MaxBalls];
	logic signed [PosW-1:0] ym [MaxBalls];
	logic [RadW-1:0] rm [MaxBalls];
	logic lm [MaxBalls];

	state_t st_q, st_d;
	logic [CntW-1:0] n_q;
	logic [IdxW-1:0] i_q, j_q, ra_q;
	logic [IdxW-1:0] rd_addr;
	logic signed [PosW-1:0] rx_q, ry_q, xi_q, yi_q, xj_q, yj_q;
	logic [RadW-1:0] rr_q, ri_q;
	logic rl_q, li_q;
	logic signed [DifW-1:0] dx_q, dy_q;
	logic [D2W-1:0] d2_q;
	logic [D2W-1:0] d2_sum;
	logic [2*RadW+1:0] rs_sq;
	logic [SqW-1:0] sv_q, sres_q, sbit_q;
	logic [RadW:0] rs_q;
	logic signed [PosW+1:0] sx_q, sy_q;
	logic [NumW-1:0] num_q;
	logic dstart_q;
	logic ddone;
	logic [NumW-1:0] quo;
	logic [RootW-1:0] root_val;
	logic [RootW:0] e_val;
	logic signed [DifW-1:0] dsel;
	logic [DifW-1:0] dmag;
	logic [2*DifW-1:0] sq;
	logic [SqW-1:0] strial;
	logic in_acc, out_acc, wr_load;
	logic signed [PosW+1:0] shift_v;

	// Read address: look one beat ahead while emitting so data lines up with the index.
	assign rd_addr = (st_q == ST_ORD) ? '0 :
		(st_q == ST_OUT && out_acc && !last_result) ? ra_q + 6'd1 : ra_q;

	// Read port: registered read at a sequencer-chosen address.
	always_ff @(posedge clk) begin
		rx_q <= xm[rd_addr];
		ry_q <= ym[rd_addr];
		rr_q <= rm[rd_addr];
		rl_q <= lm[rd_addr];
	end
	// Write port: load beats, then pair updates.
	always_ff @(posedge clk) begin
		if (wr_load) begin
			xm[n_q[IdxW-1:0]] <= pos_x;
			ym[n_q[IdxW-1:0]] <= pos_y;
			rm[n_q[IdxW-1:0]] <= circle_radius;
			lm[n_q[IdxW-1:0]] <= is_link;
		end else if (st_q == ST_WRI) begin
			xm[i_q] <= sat_pos(22'(xi_q) - sx_q);
			ym[i_q] <= sat_pos(22'(yi_q) - sy_q);
		end else if (st_q == ST_WRJ) begin
			xm[j_q] <= sat_pos(22'(xj_q) + sx_q);
			ym[j_q] <= sat_pos(22'(yj_q) + sy_q);
		end
	end

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign wr_load = in_acc && (n_q < CntW'(MaxBalls));
	assign in_stall = (st_q != ST_LOAD);
	assign out_valid = (st_q == ST_OUT);
	assign ball_index = ra_q;
	assign new_x = rx_q;
	assign new_y = ry_q;
	assign last_result = (7'(ra_q) + 7'd1 == n_q);

	assign root_val = sres_q[RootW-1:0];
	assign e_val = {rs_q, {Guard{1'b0}}} - {1'b0, root_val};
	assign dsel = (st_q == ST_D2B) ? dx_q : dy_q;
	assign dmag = dsel[DifW-1] ? DifW'(-dsel) : dsel;
	assign sq = dmag * dmag;
	assign d2_sum = d2_q + D2W'(sq);
	assign rs_sq = (2*RadW+2)'(rs_q) * (2*RadW+2)'(rs_q);
	assign strial = sres_q | sbit_q;
	assign shift_v = 22'(quo[21:0]);

	// Sequencer next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_LOAD: if (in_acc && last_ball) st_d = ST_PI;
			ST_PI: st_d = (n_q < 7'd2) ? ST_ORD : ST_PJ;
			ST_PJ: st_d = ST_RDI;
			ST_RDI: st_d = ST_RDJ;
			ST_RDJ: st_d = ST_D2A;
			ST_D2A: st_d = (li_q && rl_q) ? ST_NEXT : ST_D2B;
			ST_D2B: st_d = ST_TEST;
			ST_TEST: st_d = (d2_sum == '0 || d2_sum >= D2W'(rs_sq))
				? ST_NEXT : ST_SQRT;
			ST_SQRT: if (sbit_q == '0) st_d = ST_EX;
			ST_EX: st_d = ST_DVX;
			ST_DVX: if (ddone) st_d = ST_EY;
			ST_EY: st_d = ST_DVY;
			ST_DVY: if (ddone) st_d = ST_WRI;
			ST_WRI: st_d = ST_WRJ;
			ST_WRJ: st_d = ST_NEXT;
			ST_NEXT: st_d = (7'(j_q) + 7'd1 < n_q) ? ST_PJ :
				(7'(i_q) + 7'd2 < n_q) ? ST_PJ : ST_ORD;
			ST_ORD: st_d = ST_OUT;
			ST_OUT: if (out_acc && last_result) st_d = ST_LOAD;
			default: st_d = ST_LOAD;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			n_q <= '0;
			dstart_q <= 1'b0;
		end else begin
			st_q <= st_d;
			dstart_q <= (st_q == ST_EX) || (st_q == ST_EY);
			if (wr_load) n_q <= n_q + 7'd1;
			if (st_q == ST_OUT && out_acc && last_result) n_q <= '0;
		end
	end

	// Datapath: pair indices, operand capture, root and shift.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_PI: begin
				i_q <= '0;
				j_q <= 6'd1;
			end
			ST_PJ: ra_q <= i_q;
			ST_RDI: ra_q <= j_q;
			ST_RDJ: begin
				xi_q <= rx_q; yi_q <= ry_q; ri_q <= rr_q; li_q <= rl_q;
			end
			ST_D2A: begin
				xj_q <= rx_q; yj_q <= ry_q;
				rs_q <= 15'(ri_q) + 15'(rr_q);
				dx_q <= 21'(rx_q) - 21'(xi_q);
				dy_q <= 21'(ry_q) - 21'(yi_q);
			end
			ST_D2B: d2_q <= D2W'(sq);
			ST_TEST: begin
				d2_q <= d2_sum;
				sv_q <= SqW'(d2_sum) << (2 * Guard);
				sres_q <= '0;
				sbit_q <= SqW'(1) << (SqW - 2);
			end
			ST_SQRT: begin
				if (sbit_q != '0) begin
					if (sv_q >= strial) begin
						sv_q <= sv_q - strial;
						sres_q <= (sres_q >> 1) | sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end
			end
			ST_EX: num_q <= NumW'(e_val) * NumW'(dx_q[DifW-1] ? 21'(-dx_q) : dx_q)
				+ NumW'(root_val);
			ST_DVX: if (ddone) sx_q <= dx_q[DifW-1] ? -shift_v : shift_v;
			ST_EY: num_q <= NumW'(e_val) * NumW'(dy_q[DifW-1] ? 21'(-dy_q) : dy_q)
				+ NumW'(root_val);
			ST_DVY: if (ddone) sy_q <= dy_q[DifW-1] ? -shift_v : shift_v;
			ST_NEXT: begin
				if (7'(j_q) + 7'd1 < n_q) begin
					j_q <= j_q + 6'd1;
				end else begin
					i_q <= i_q + 6'd1;
					j_q <= i_q + 6'd2;
				end
			end
			ST_ORD: ra_q <= '0;
			ST_OUT: if (out_acc && !last_result) ra_q <= ra_q + 6'd1;
			default: ;
		endcase
	end

	// Shared divider for both axis shifts.
	pccr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q),
		.num(num_q), .den({root_val, 1'b0}), .done(ddone), .quo(quo)
	);
endmodule
`default_nettype wire

// ===== rtl/pccr_checker.sv =====
// Port-level checker for the collision resolver, bound to the top level.
// Depends on pccr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pccr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [pccr_pkg::IdxW-1:0] ball_index,
	input wire logic last_result
);
	import pccr_pkg::*;
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while emitting");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_result) |=> ball_index == $past(ball_index) + 6'd1)
		else $error("index skipped");
	a_first_idx: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ball_index == '0) else $error("run not at zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(ball_index))
		else $error("stalled beat changed");
endmodule
bind pairwise_circle_collision_resolve pccr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .ball_index(ball_index),
	.last_result(last_result)
);
`default_nettype wire
